// File: hw/rtl/hsvrgb_pkg.sv
package hsvrgb_pkg;

    localparam int HUE_W  = 9;
    localparam int PCT_W  = 7;
    localparam int BYTE_W = 8;
    localparam int CFG_INDEX_W = 2;

    // Scaled hue H = hue * 10 / 6 spans 0..851, so the sector can reach 8.
    localparam int HS_W     = 10;
    localparam int SECTOR_W = 4;
    localparam int FRAC_W   = 7;
    localparam int SPROD_W  = 14;
    localparam int XTERM_W  = 10;
    localparam int SHADE_N_W = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_SATURATION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS = 2'd1;

    localparam logic [PCT_W-1:0] SAT_RESET = 7'd100;
    localparam logic [PCT_W-1:0] VAL_RESET = 7'd20;
    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [XTERM_W-1:0] PERMILLE_FULL = 10'd1000;

    localparam logic [SECTOR_W-1:0] SECTOR_0 = 4'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_1 = 4'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_2 = 4'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_3 = 4'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_4 = 4'd4;

    // Reciprocal multipliers; each one is exact over the operand range it sees.
    localparam int HUE_MUL   = 13655;   // 5 * ceil(2^13 / 3): hue * 5 / 3
    localparam int HUE_SHIFT = 13;
    localparam int SEC_MUL   = 41;      // ceil(2^12 / 100)
    localparam int SEC_SHIFT = 12;
    localparam int DIV100_MUL   = 5243; // ceil(2^19 / 100)
    localparam int DIV100_SHIFT = 19;
    localparam int DIV10_MUL    = 6554; // ceil(2^16 / 10)
    localparam int DIV10_SHIFT  = 16;
    localparam int DIV1000_MUL   = 134218; // ceil(2^27 / 1000)
    localparam int DIV1000_SHIFT = 27;
    localparam int BYTE_MUL   = 1336965;  // 255 * ceil(2^19 / 100)
    localparam int BYTE_SHIFT = 19;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [FRAC_W-1:0]   frac;
    } hue_split_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [PCT_W-1:0]    p;
        logic [PCT_W-1:0]    q;
        logic [PCT_W-1:0]    t;
    } shade_t;

    // Pipeline control shared by all stages.
    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctl_t;

    function automatic logic [PCT_W-1:0] pct_clamp(input logic [PCT_W-1:0] x);
        return (x > PCT_FULL) ? PCT_FULL : x;
    endfunction

    // 255 * x / 100 for x in 0..100.
    function automatic logic [BYTE_W-1:0] pct_to_byte(input logic [PCT_W-1:0] x);
        logic [27:0] prod;
        prod = 28'(x) * 28'(BYTE_MUL);
        return prod[BYTE_SHIFT+BYTE_W-1:BYTE_SHIFT];
    endfunction

endpackage

// File: hw/rtl/hsvrgb_hue_split.sv
module hsvrgb_hue_split (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hsvrgb_pkg::pipe_ctl_t       ctl_in,
    input  logic [hsvrgb_pkg::HUE_W-1:0] hue,
    output logic                        valid_out,
    output hsvrgb_pkg::hue_split_t      split_out
);
    import hsvrgb_pkg::*;

    // Three stages: scale the hue, find the sector, then the fraction.
    logic                v1_reg, v2_reg, v3_reg;
    logic [HS_W-1:0]     hs1_reg, hs2_reg;
    logic [SECTOR_W-1:0] sec2_reg;
    hue_split_t          split3_reg;

    logic [22:0]         hs_prod;
    logic [HS_W-1:0]     hs1_next;
    logic [15:0]         sec_prod;
    logic [SECTOR_W-1:0] sec2_next;
    logic [HS_W-1:0]     sec_base;
    logic [HS_W-1:0]     frac_diff;
    hue_split_t          split3_next;

    always_comb
    begin
        hs_prod   = 23'(hue) * 23'(HUE_MUL);
        hs1_next  = hs_prod[HUE_SHIFT+HS_W-1:HUE_SHIFT];
        sec_prod  = 16'(hs1_reg) * 16'(SEC_MUL);
        sec2_next = sec_prod[SEC_SHIFT+SECTOR_W-1:SEC_SHIFT];
        sec_base  = HS_W'(sec2_reg) * HS_W'(PCT_FULL);
        frac_diff = hs2_reg - sec_base;
        split3_next.sector = sec2_reg;
        split3_next.frac   = frac_diff[FRAC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ctl_in.advance)
        begin
            v1_reg <= ctl_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.advance)
        begin
            hs1_reg    <= hs1_next;
            hs2_reg    <= hs1_reg;
            sec2_reg   <= sec2_next;
            split3_reg <= split3_next;
        end
    end

    assign valid_out = v3_reg;
    assign split_out = split3_reg;

endmodule

// File: hw/rtl/hsvrgb_shade.sv
module hsvrgb_shade (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hsvrgb_pkg::pipe_ctl_t        ctl_in,
    input  hsvrgb_pkg::hue_split_t       split_in,
    input  logic [hsvrgb_pkg::PCT_W-1:0] sat,
    input  logic [hsvrgb_pkg::PCT_W-1:0] val,
    output logic                         valid_out,
    output hsvrgb_pkg::shade_t           shade_out
);
    import hsvrgb_pkg::*;

    // Stage 4 forms the saturation products, stage 5 divides them by ten
    // (and p by one hundred), stage 6 scales by value, stage 7 divides by
    // one thousand.
    logic                 v4_reg, v5_reg, v6_reg, v7_reg;
    logic [SECTOR_W-1:0]  sec4_reg, sec5_reg, sec6_reg;
    logic [SPROD_W-1:0]   sf4_reg, sg4_reg, pn4_reg;
    logic [XTERM_W-1:0]   xq5_reg, xt5_reg;
    logic [PCT_W-1:0]     p5_reg, p6_reg;
    logic [SHADE_N_W-1:0] qn6_reg, tn6_reg;
    shade_t               shade7_reg;

    logic [29:0]          xq_prod, xt_prod;
    logic [26:0]          p_prod;
    logic [34:0]          q_prod, t_prod;
    shade_t               shade7_next;

    always_comb
    begin
        xq_prod = 30'(sf4_reg) * 30'(DIV10_MUL);
        xt_prod = 30'(sg4_reg) * 30'(DIV10_MUL);
        p_prod  = 27'(pn4_reg) * 27'(DIV100_MUL);
        q_prod  = 35'(qn6_reg) * 35'(DIV1000_MUL);
        t_prod  = 35'(tn6_reg) * 35'(DIV1000_MUL);
        shade7_next.sector = sec6_reg;
        shade7_next.p      = p6_reg;
        shade7_next.q      = q_prod[DIV1000_SHIFT+PCT_W-1:DIV1000_SHIFT];
        shade7_next.t      = t_prod[DIV1000_SHIFT+PCT_W-1:DIV1000_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (ctl_in.advance)
        begin
            v4_reg <= ctl_in.valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.advance)
        begin
            sec4_reg <= split_in.sector;
            sf4_reg  <= SPROD_W'(sat) * SPROD_W'(split_in.frac);
            sg4_reg  <= SPROD_W'(sat) * SPROD_W'(PCT_FULL - split_in.frac);
            pn4_reg  <= SPROD_W'(val) * SPROD_W'(PCT_FULL - sat);

            sec5_reg <= sec4_reg;
            xq5_reg  <= xq_prod[DIV10_SHIFT+XTERM_W-1:DIV10_SHIFT];
            xt5_reg  <= xt_prod[DIV10_SHIFT+XTERM_W-1:DIV10_SHIFT];
            p5_reg   <= p_prod[DIV100_SHIFT+PCT_W-1:DIV100_SHIFT];

            sec6_reg <= sec5_reg;
            p6_reg   <= p5_reg;
            qn6_reg  <= SHADE_N_W'(val) * SHADE_N_W'(PERMILLE_FULL - xq5_reg);
            tn6_reg  <= SHADE_N_W'(val) * SHADE_N_W'(PERMILLE_FULL - xt5_reg);

            shade7_reg <= shade7_next;
        end
    end

    assign valid_out = v7_reg;
    assign shade_out = shade7_reg;

endmodule

// File: hw/rtl/hsvrgb_mix.sv
module hsvrgb_mix (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hsvrgb_pkg::pipe_ctl_t         ctl_in,
    input  hsvrgb_pkg::shade_t            shade_in,
    input  logic [hsvrgb_pkg::PCT_W-1:0]  sat,
    input  logic [hsvrgb_pkg::PCT_W-1:0]  val,
    output logic                          valid_out,
    output logic [hsvrgb_pkg::BYTE_W-1:0] red_out,
    output logic [hsvrgb_pkg::BYTE_W-1:0] green_out,
    output logic [hsvrgb_pkg::BYTE_W-1:0] blue_out
);
    import hsvrgb_pkg::*;

    logic             v8_reg, v9_reg;
    logic [PCT_W-1:0] r8_reg, g8_reg, b8_reg;
    logic [PCT_W-1:0] r8_next, g8_next, b8_next;
    logic [BYTE_W-1:0] red_reg, green_reg, blue_reg;

    always_comb
    begin
        r8_next = val;
        g8_next = val;
        b8_next = val;
        if (sat != '0)
        begin
            case (shade_in.sector)
                SECTOR_0:
                begin
                    r8_next = val;        g8_next = shade_in.t; b8_next = shade_in.p;
                end
                SECTOR_1:
                begin
                    r8_next = shade_in.q; g8_next = val;        b8_next = shade_in.p;
                end
                SECTOR_2:
                begin
                    r8_next = shade_in.p; g8_next = val;        b8_next = shade_in.t;
                end
                SECTOR_3:
                begin
                    r8_next = shade_in.p; g8_next = shade_in.q; b8_next = val;
                end
                SECTOR_4:
                begin
                    r8_next = shade_in.t; g8_next = shade_in.p; b8_next = val;
                end
                default:
                begin
                    // Sector five, and any higher sector from a hue past 359.
                    r8_next = val;        g8_next = shade_in.p; b8_next = shade_in.q;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (ctl_in.advance)
        begin
            v8_reg <= ctl_in.valid;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.advance)
        begin
            r8_reg    <= r8_next;
            g8_reg    <= g8_next;
            b8_reg    <= b8_next;
            red_reg   <= pct_to_byte(r8_reg);
            green_reg <= pct_to_byte(g8_reg);
            blue_reg  <= pct_to_byte(b8_reg);
        end
    end

    assign valid_out = v9_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

endmodule

// File: hw/rtl/hsv_to_rgb_percent_converter_unit.sv
// HSV to RGB converter: each word on the hue channel carries a hue in whole
// degrees, and the matching word on the rgb channel carries 8-bit red, green
// and blue. The pipeline takes one hue every cycle unless stalled; its nine
// register stages all advance together and hold while a finished word waits
// on rgb_ready, so a stall neither drops nor repeats a word. Saturation
// (index 0, reset 100) and brightness (index 1, reset 20) are percent
// registers written through the cfg channel, which is always ready; values
// above 100 are stored as written but used as 100, and writes to other
// indexes are ignored. Write them only while no hue is in flight. Zero
// saturation gives grey at 255 * brightness / 100 on all three channels.
// Hues above 359 are not wrapped: any sector past the fifth uses the fifth
// sector's channel assignment.
module hsv_to_rgb_percent_converter_unit (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                hue_valid,
    output logic                                hue_ready,
    input  logic [hsvrgb_pkg::HUE_W-1:0]        hue_deg,

    output logic                                rgb_valid,
    input  logic                                rgb_ready,
    output logic [hsvrgb_pkg::BYTE_W-1:0]       red_out,
    output logic [hsvrgb_pkg::BYTE_W-1:0]       green_out,
    output logic [hsvrgb_pkg::BYTE_W-1:0]       blue_out,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hsvrgb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hsvrgb_pkg::PCT_W-1:0]        cfg_data
);
    import hsvrgb_pkg::*;

    logic [PCT_W-1:0] sat_reg, val_reg;
    logic [PCT_W-1:0] sat_next, val_next;
    logic [PCT_W-1:0] sat_use, val_use;

    logic       advance;
    pipe_ctl_t  split_ctl, shade_ctl, mix_ctl;
    logic       split_valid, shade_valid;
    hue_split_t split_word;
    shade_t     shade_word;

    // Configuration registers; the clamped copies feed stages 4 to 9 directly.
    // The user must write them only while the pipeline is empty; unenforced.
    always_comb
    begin
        sat_next = sat_reg;
        val_next = val_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SATURATION: sat_next = cfg_data;
                CFG_BRIGHTNESS: val_next = cfg_data;
                default:
                begin
                    sat_next = sat_reg;
                    val_next = val_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= SAT_RESET;
            val_reg <= VAL_RESET;
        end
        else
        begin
            sat_reg <= sat_next;
            val_reg <= val_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign sat_use   = pct_clamp(sat_reg);
    assign val_use   = pct_clamp(val_reg);

    // The whole pipeline moves whenever the output register is empty or its
    // word is being taken this cycle.
    assign advance   = !rgb_valid || rgb_ready;
    assign hue_ready = advance;

    assign split_ctl = '{advance: advance, valid: hue_valid};
    assign shade_ctl = '{advance: advance, valid: split_valid};
    assign mix_ctl   = '{advance: advance, valid: shade_valid};

    // Stages 1 to 3: scaled hue, sector and fraction.
    hsvrgb_hue_split u_hue_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (split_ctl),
        .hue       (hue_deg),
        .valid_out (split_valid),
        .split_out (split_word)
    );

    // Stages 4 to 7: the p, q and t levels.
    hsvrgb_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (shade_ctl),
        .split_in  (split_word),
        .sat       (sat_use),
        .val       (val_use),
        .valid_out (shade_valid),
        .shade_out (shade_word)
    );

    // Stages 8 and 9: channel assignment and scaling to bytes.
    hsvrgb_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (mix_ctl),
        .shade_in  (shade_word),
        .sat       (sat_use),
        .val       (val_use),
        .valid_out (rgb_valid),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

endmodule
